### rtl/note_beep_sequencer_macros.svh
// Assertion macros shared by the note beep sequencer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef NOTE_BEEP_SEQUENCER_MACROS_SVH
`define NOTE_BEEP_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NBS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/nbs_pkg.sv
// Shared types, constants and the note period table for the note beep sequencer.
// No dependencies; used by every module of the block by scoped names.
`default_nettype none

package nbs_pkg;

	localparam int RELOAD_W = 13;
	localparam int COMPARE_W = 12;
	localparam int NOTE_W = 5;
	localparam int LEN_W = 4;
	localparam int NOW_W = 32;
	localparam int PHASE_W = 2;

	// Play limit is 40 ms shifted left by a length code of up to 15.
	localparam int LIMIT_W = 21;
	localparam logic [LIMIT_W-1:0] LIMIT_BASE = 21'd40;

	// Phase codes as seen on the result beats.
	localparam logic [PHASE_W-1:0] PHASE_CODE_IDLE = 2'd0;
	localparam logic [PHASE_W-1:0] PHASE_CODE_PLAYING = 2'd1;
	localparam logic [PHASE_W-1:0] PHASE_CODE_STOPPED = 2'd2;

	// Register map: word index taken from paddr[2].
	localparam logic REG_MUTE_ENABLE = 1'b0;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_PLAYING = 3'b010,
		PH_STOPPED = 3'b100
	} nbs_phase_t;

	typedef struct packed {
		logic request;
		logic [NOTE_W-1:0] note_index;
		logic [LEN_W-1:0] length_code;
		logic [NOW_W-1:0] now_ms;
	} nbs_item_t;

	typedef struct packed {
		logic [RELOAD_W-1:0] period_reload;
		logic [COMPARE_W-1:0] duty_compare;
		logic acknowledge;
		logic [PHASE_W-1:0] phase;
	} nbs_result_t;

	typedef struct packed {
		logic [RELOAD_W-1:0] reload;
		logic [COMPARE_W-1:0] compare;
	} nbs_tone_t;

	// PWM settings per note: period is 1e6 / frequency in microseconds,
	// reload is period - 1 and compare is half the period. Rest and the
	// unused indexes above 22 give silence.
	function automatic nbs_tone_t note_tone(input logic [NOTE_W-1:0] idx);
		nbs_tone_t t;
		case (idx)
			5'd1: t = '{13'd7632, 12'd3816};
			5'd2: t = '{13'd6801, 12'd3401};
			5'd3: t = '{13'd6059, 12'd3030};
			5'd4: t = '{13'd5713, 12'd2857};
			5'd5: t = '{13'd5101, 12'd2551};
			5'd6: t = '{13'd4544, 12'd2272};
			5'd7: t = '{13'd4047, 12'd2024};
			5'd8: t = '{13'd3815, 12'd1908};
			5'd9: t = '{13'd3400, 12'd1700};
			5'd10: t = '{13'd3029, 12'd1515};
			5'd11: t = '{13'd2864, 12'd1432};
			5'd12: t = '{13'd2550, 12'd1275};
			5'd13: t = '{13'd2271, 12'd1136};
			5'd14: t = '{13'd2023, 12'd1012};
			5'd15: t = '{13'd1911, 12'd956};
			5'd16: t = '{13'd1702, 12'd851};
			5'd17: t = '{13'd1516, 12'd758};
			5'd18: t = '{13'd1431, 12'd716};
			5'd19: t = '{13'd1274, 12'd637};
			5'd20: t = '{13'd1135, 12'd568};
			5'd21: t = '{13'd1011, 12'd506};
			5'd22: t = '{13'd954, 12'd477};
			default: t = '{'0, '0};
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

### rtl/nbs_apb_regs.sv
// APB register slice of the note beep sequencer: holds the mute enable bit.
// Depends on nbs_pkg for the register map.
`default_nettype none

module nbs_apb_regs (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output logic             mute_enable
);

	logic mute_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mute_q <= 1'b0;
		end else if (wr_en && (paddr[2] == nbs_pkg::REG_MUTE_ENABLE)) begin
			mute_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == nbs_pkg::REG_MUTE_ENABLE) begin
			prdata = {31'd0, mute_q};
		end
	end

	assign mute_enable = mute_q;

endmodule

`default_nettype wire

### rtl/nbs_seq_core.sv
// Phase sequencer of the note beep sequencer: state registers and the poll update.
// Depends on nbs_pkg and note_beep_sequencer_macros.svh.
`default_nettype none
`include "note_beep_sequencer_macros.svh"

module nbs_seq_core #(
	parameter int NOTE_COUNT = 23,
	parameter int TIME_BITS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               advance,
	input  wire nbs_pkg::nbs_item_t item,
	input  wire logic               mute_enable,
	output nbs_pkg::nbs_result_t    result
);

	localparam int CMP_W = (TIME_BITS > nbs_pkg::LIMIT_W) ? TIME_BITS : nbs_pkg::LIMIT_W;
	localparam int IDX_W = nbs_pkg::NOTE_W + 1;

	nbs_pkg::nbs_phase_t phase_q, phase_d;
	logic [TIME_BITS-1:0] start_time_q, start_time_d;
	logic [nbs_pkg::RELOAD_W-1:0] reload_q, reload_d;
	logic [nbs_pkg::COMPARE_W-1:0] compare_q, compare_d;
	logic ack_q, ack_d;

	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] elapsed;
	logic [nbs_pkg::LIMIT_W-1:0] limit;
	logic expired;
	logic silent;
	nbs_pkg::nbs_tone_t tone;

	assign now_t = item.now_ms[TIME_BITS-1:0];
	assign elapsed = now_t - start_time_q;
	assign limit = nbs_pkg::LIMIT_BASE << item.length_code;
	assign expired = CMP_W'(elapsed) > CMP_W'(limit);
	assign tone = nbs_pkg::note_tone(item.note_index);
	assign silent = mute_enable || ({1'b0, item.note_index} >= IDX_W'(NOTE_COUNT));

	always_comb begin
		phase_d = phase_q;
		start_time_d = start_time_q;
		reload_d = reload_q;
		compare_d = compare_q;
		ack_d = ack_q;
		case (phase_q)
			nbs_pkg::PH_PLAYING: begin
				// The held values stay on the poll that leaves playing.
				if (!item.request || expired) begin
					phase_d = nbs_pkg::PH_STOPPED;
				end
			end
			nbs_pkg::PH_STOPPED: begin
				reload_d = '0;
				compare_d = '0;
				ack_d = item.request;
				if (!item.request) begin
					phase_d = nbs_pkg::PH_IDLE;
				end
			end
			default: begin
				phase_d = nbs_pkg::PH_IDLE;
				reload_d = '0;
				compare_d = '0;
				if (item.request) begin
					phase_d = nbs_pkg::PH_PLAYING;
					start_time_d = now_t;
					if (!silent) begin
						reload_d = tone.reload;
						compare_d = tone.compare;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= nbs_pkg::PH_IDLE;
			start_time_q <= '0;
			reload_q <= '0;
			compare_q <= '0;
			ack_q <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			start_time_q <= start_time_d;
			reload_q <= reload_d;
			compare_q <= compare_d;
			ack_q <= ack_d;
		end
	end

	always_comb begin
		result.period_reload = reload_d;
		result.duty_compare = compare_d;
		result.acknowledge = ack_d;
		case (phase_d)
			nbs_pkg::PH_PLAYING: result.phase = nbs_pkg::PHASE_CODE_PLAYING;
			nbs_pkg::PH_STOPPED: result.phase = nbs_pkg::PHASE_CODE_STOPPED;
			default: result.phase = nbs_pkg::PHASE_CODE_IDLE;
		endcase
	end

	// Acknowledge is only ever held while the sequencer sits in stopped.
	`NBS_ASSERT_SAME(a_ack_only_stopped, clk, arst_n, ack_q, phase_q == nbs_pkg::PH_STOPPED, "ack outside stopped")
	// A stopped poll always clears the held PWM values.
	`NBS_ASSERT_NEXT(a_stop_clears, clk, arst_n, advance && (phase_q == nbs_pkg::PH_STOPPED), (reload_q == '0) && (compare_q == '0), "stopped poll left PWM values")
	// A request in idle captures the poll time as the start time.
	`NBS_ASSERT_NEXT(a_start_capture, clk, arst_n, advance && (phase_q == nbs_pkg::PH_IDLE) && item.request, (start_time_q == $past(now_t)) && (phase_q == nbs_pkg::PH_PLAYING), "start time not captured")

endmodule

`default_nettype wire

### rtl/note_beep_sequencer.sv
// Each poll beat passes the input register and then the result register to m_tdata.
// Throughput: one poll per cycle; the input register and the result register keep
// moving as long as the downstream side takes beats, and either can hold one beat.
// Reset (arst_n low, asynchronous) returns the sequencer to idle with m_tvalid low,
// clears the mute enable and empties both registers. No clearing pass is needed.
// Depends on nbs_pkg, nbs_apb_regs and nbs_seq_core.
`default_nettype none

module note_beep_sequencer #(
	parameter int NOTE_COUNT = 23,
	parameter int TIME_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Poll beats.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [0] request, [5:1] note_index, [9:6] length_code, [41:10] now_ms, [47:42] zero
	input  wire logic [47:0] s_tdata,
	// Result beats.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [12:0] period_reload, [24:13] duty_compare, [25] acknowledge, [27:26] phase,
	// [31:28] zero
	output logic      [31:0] m_tdata,
	// Configuration port.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	// The input register holds one poll beat. It hands the beat to the
	// sequencer core, which updates its state and produces the result
	// for the output register in the same cycle.
	logic valid_s1;
	nbs_pkg::nbs_item_t item_s1;
	logic out_valid_q;
	nbs_pkg::nbs_result_t out_q;

	logic out_free;
	logic advance;
	logic in_take;
	logic mute_enable;
	nbs_pkg::nbs_result_t result;

	// The output register can load when it is empty or is being emptied.
	assign out_free = !out_valid_q || m_tready;
	assign advance = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign in_take = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload of the input register needs no reset.
	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.request <= s_tdata[0];
			item_s1.note_index <= s_tdata[5:1];
			item_s1.length_code <= s_tdata[9:6];
			item_s1.now_ms <= s_tdata[41:10];
		end
	end

	nbs_apb_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.mute_enable (mute_enable)
	);

	nbs_seq_core #(
		.NOTE_COUNT (NOTE_COUNT),
		.TIME_BITS  (TIME_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.item        (item_s1),
		.mute_enable (mute_enable),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {4'd0, out_q.phase, out_q.acknowledge, out_q.duty_compare,
		out_q.period_reload};

endmodule

`default_nettype wire
